// ===== rtl/vfsp_pkg.sv =====
// Shared types and constants for the voice frame slot placer.
// Holds field widths, stream packing widths and the item and result structs.
// No dependencies.
`timescale 1ns / 1ps

package vfsp_pkg;

  // Default ring geometry
  localparam int RING_SLOTS_DEF = 84;
  localparam int SYNC_SLOTS_DEF = 21;

  // Field widths
  localparam int NUM_W  = 5;
  localparam int POS_W  = 7;
  localparam int VLO_W  = 64;
  localparam int VHI_W  = 8;
  localparam int SLOW_W = 24;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 104;

  // Slow-data bytes that request end of transmission
  localparam logic [SLOW_W-1:0] END_SLOW_PATTERN = 24'h555555;

  typedef struct packed {
    logic [NUM_W-1:0]  frame_number;
    logic              end_flag;
    logic [POS_W-1:0]  tx_position;
    logic [VLO_W-1:0]  voice_low;
    logic [VHI_W-1:0]  voice_high;
    logic [SLOW_W-1:0] slow_data;
  } item_t;

  typedef struct packed {
    logic              store_valid;
    logic [POS_W-1:0]  slot_index;
    logic [VLO_W-1:0]  voice_low_out;
    logic [VHI_W-1:0]  voice_high_out;
    logic [SLOW_W-1:0] slow_data_out;
    logic              end_transmit;
  } result_t;

endpackage

// ===== rtl/vfsp_place.sv =====
// Placement logic: area start, seen bitmap and last number registers plus
// the combinational slot computation for one frame.
// Depends on vfsp_pkg.
`timescale 1ns / 1ps

module vfsp_place #(
  parameter int RING_SLOTS = vfsp_pkg::RING_SLOTS_DEF,
  parameter int SYNC_SLOTS = vfsp_pkg::SYNC_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  vfsp_pkg::item_t   item,
  output vfsp_pkg::result_t result
);

  localparam int AW = $clog2(RING_SLOTS);
  localparam int CW = $clog2(2 * RING_SLOTS) + 1;
  localparam int IW = (SYNC_SLOTS > 1) ? $clog2(SYNC_SLOTS) : 1;
  localparam logic [CW-1:0] RING_C  = CW'(RING_SLOTS);
  localparam logic [CW-1:0] RING2_C = CW'(2 * RING_SLOTS);
  localparam logic [CW-1:0] SYNC_C  = CW'(SYNC_SLOTS);
  localparam logic [CW-1:0] LIMIT_C = CW'(RING_SLOTS - SYNC_SLOTS);
  localparam logic [vfsp_pkg::NUM_W-1:0] LAST_NUM = vfsp_pkg::NUM_W'(SYNC_SLOTS - 1);

  logic [AW-1:0]              area_r, area_nxt;
  logic [SYNC_SLOTS-1:0]      seen_r, seen_nxt;
  logic [vfsp_pkg::NUM_W-1:0] last_r, last_nxt;

  logic                  num_ok;
  logic [IW-1:0]         num_idx;
  logic [SYNC_SLOTS-1:0] num_bit;
  logic                  restart;
  logic [AW-1:0]         area_a, area_b;
  logic [CW-1:0]         num_c, tx_c, tx_a, tx_m, pos, behind, slot;
  logic                  store;

  // Step the area start by one sync interval, wrapping to zero
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] a);
    logic [CW-1:0] s;
    s = CW'(a) + SYNC_C;
    return (s > LIMIT_C) ? '0 : s[AW-1:0];
  endfunction

  always_comb begin
    num_c   = CW'(item.frame_number);
    num_ok  = num_c < SYNC_C;
    num_idx = item.frame_number[IW-1:0];
    num_bit = SYNC_SLOTS'(1) << num_idx;

    // Repeat or wrap of the number opens a new area
    restart = ((seen_r & num_bit) != '0) ||
              (item.frame_number == '0 && last_r == LAST_NUM);
    area_a  = restart ? adv(area_r) : area_r;

    // Reduce transmit position into the ring
    tx_c = CW'(item.tx_position);
    tx_a = (tx_c >= RING2_C) ? tx_c - RING2_C : tx_c;
    tx_m = (tx_a >= RING_C) ? tx_a - RING_C : tx_a;

    // Move on when the slot lands just behind the transmit position
    pos    = CW'(area_a) + num_c;
    behind = (pos >= tx_m) ? pos - tx_m : pos + RING_C - tx_m;
    area_b = (behind >= LIMIT_C) ? adv(area_a) : area_a;
    slot   = CW'(area_b) + num_c;

    store = !item.end_flag && num_ok;

    // Hold state unless a frame is stored
    area_nxt = area_r;
    seen_nxt = seen_r;
    last_nxt = last_r;
    if (step && store) begin
      area_nxt = area_b;
      seen_nxt = (restart ? '0 : seen_r) | num_bit;
      last_nxt = item.frame_number;
    end

    // Build the result; when nothing is stored, all fields are zero but end_transmit
    result                = '0;
    result.end_transmit   = item.end_flag;
    if (store) begin
      result.store_valid    = 1'b1;
      result.slot_index     = slot[vfsp_pkg::POS_W-1:0];
      result.voice_low_out  = item.voice_low;
      result.voice_high_out = item.voice_high;
      result.slow_data_out  = item.slow_data;
      result.end_transmit   = (item.slow_data == vfsp_pkg::END_SLOW_PATTERN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= '0;
      seen_r <= '0;
      last_r <= '0;
    end else begin
      area_r <= area_nxt;
      seen_r <= seen_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

// ===== rtl/voice_frame_slot_placer.sv =====
// Voice frame slot placer: takes one frame per clock on the input stream while
// the output is not stalled and gives exactly one result per frame. The sustained
// rate is one frame per cycle without output stalls, set by the combinational
// placement logic that reads and updates the area registers. Each frame's slot in
// the ring is its number plus the current area start; the result flag in out_tuser
// says whether the frame was stored, and out_tlast requests end of transmission.
// An input register and an output register part the two sides.
// Depends on vfsp_pkg and vfsp_place.
`timescale 1ns / 1ps

module voice_frame_slot_placer #(
  parameter int RING_SLOTS = vfsp_pkg::RING_SLOTS_DEF,
  parameter int SYNC_SLOTS = vfsp_pkg::SYNC_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // frame_number[4:0], tx_position[11:5], voice_low[75:12],
  // voice_high[83:76], slow_data[107:84], zero pad above
  input  logic [vfsp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,  // end_flag
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // slot_index[6:0], voice_low_out[70:7], voice_high_out[78:71],
  // slow_data_out[102:79], zero pad above
  output logic [vfsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser, // store_valid
  output logic                             out_tlast  // end_transmit
);

  logic              in_valid_r, in_valid_nxt;
  vfsp_pkg::item_t   in_item_r, in_item_nxt;
  logic              out_valid_r, out_valid_nxt;
  vfsp_pkg::result_t out_res_r, out_res_nxt;
  vfsp_pkg::item_t   in_item;
  vfsp_pkg::result_t result;
  logic              s1_adv;
  logic              step;

  // Unpack the input transfer
  always_comb begin
    in_item.frame_number = in_tdata[4:0];
    in_item.tx_position  = in_tdata[11:5];
    in_item.voice_low    = in_tdata[75:12];
    in_item.voice_high   = in_tdata[83:76];
    in_item.slow_data    = in_tdata[107:84];
    in_item.end_flag     = in_tlast;
  end

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || s1_adv;
  assign step      = in_valid_r && s1_adv;

  vfsp_place #(
    .RING_SLOTS(RING_SLOTS),
    .SYNC_SLOTS(SYNC_SLOTS)
  ) u_place (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .result (result)
  );

  // Advance the input and output registers
  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_item_nxt   = in_item_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      in_item_nxt  = in_item;
    end else if (s1_adv) begin
      in_valid_nxt = 1'b0;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = result;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  // Pack the result transfer
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.store_valid;
  assign out_tlast  = out_res_r.end_transmit;
  assign out_tdata  = {1'b0, out_res_r.slow_data_out, out_res_r.voice_high_out,
                       out_res_r.voice_low_out, out_res_r.slot_index};

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for voice_frame_slot_placer.
// Streams directed and random voice frames, predicts slot placement per transfer
// and checks every result in order. Depends on vfsp_pkg and the placer RTL.
`timescale 1ns / 1ps

module tb;
  import vfsp_pkg::*;

  localparam int RING        = RING_SLOTS_DEF;
  localparam int SYNC        = SYNC_SLOTS_DEF;
  localparam int RAND_FRAMES = 1950;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 20;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  item_t   pending_frames[$];
  result_t expected_slots[$];
  item_t   drv_frame;
  int      frames_total = 0;
  int      frames_sent = 0;
  int      err_count = 0;
  int      cycle_count = 0;
  int      in_gap = 0;
  int      out_stall = 0;

  // predictor state
  logic [POS_W-1:0] plc_area = '0;
  logic [SYNC-1:0]  plc_seen = '0;
  logic [NUM_W-1:0] plc_last = '0;

  voice_frame_slot_placer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Step to the next area, wrapping once past the last full area
  function automatic void next_area();
    int unsigned a;
    a = plc_area + SYNC;
    if (a > RING - SYNC) a = 0;
    plc_area = POS_W'(a);
  endfunction

  // Work out the slot result for one frame and update the placement state
  function automatic result_t place_frame(input item_t f);
    result_t     r;
    int unsigned num;
    int unsigned pos;
    int unsigned behind;
    r = '0;
    num = f.frame_number;
    pos = f.tx_position % RING;
    if (f.end_flag) begin
      r.end_transmit = 1'b1;
      return r;
    end
    if (num >= SYNC) return r;
    if (plc_seen[num] || (num == 0 && plc_last == SYNC - 1)) begin
      next_area();
      plc_seen = '0;
    end
    plc_seen[num] = 1'b1;
    behind = (plc_area + num + RING - pos) % RING;
    if (behind >= RING - SYNC) next_area();
    plc_last = NUM_W'(num);
    r.store_valid    = 1'b1;
    r.slot_index     = POS_W'(plc_area + num);
    r.voice_low_out  = f.voice_low;
    r.voice_high_out = f.voice_high;
    r.slow_data_out  = f.slow_data;
    r.end_transmit   = (f.slow_data == END_SLOW_PATTERN);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and stretches with none
  function automatic int pick_gap();
    int r;
    if (cycle_count % 700 < 150) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_frame(input int num, input bit endf, input int pos,
                           input logic [VLO_W-1:0] vlo, input logic [VHI_W-1:0] vhi,
                           input logic [SLOW_W-1:0] slow);
    item_t f;
    f.frame_number = NUM_W'(num);
    f.end_flag     = endf;
    f.tx_position  = POS_W'(pos);
    f.voice_low    = vlo;
    f.voice_high   = vhi;
    f.slow_data    = slow;
    pending_frames.push_back(f);
    frames_total++;
  endtask

  // Frame with random voice and slow data, now and then the end pattern
  task automatic add_random_frame(input int num, input bit endf, input int pos);
    logic [SLOW_W-1:0] slow;
    slow = ($urandom_range(0, 19) == 0) ? END_SLOW_PATTERN : SLOW_W'($urandom);
    add_frame(num, endf, pos, {$urandom, $urandom}, VHI_W'($urandom), slow);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0d] mismatch on %s: got %0h, want %0h", cycle_count, field, got, want);
    err_count++;
  endtask

  // Drive frames from the pending queue; predict each one on its transfer
  always @(posedge clk) begin
    logic [IN_TDATA_W-1:0] word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_slots.push_back(place_frame(drv_frame));
        frames_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          drv_frame = pending_frames.pop_front();
          word = '0;
          word[4:0]    = drv_frame.frame_number;
          word[11:5]   = drv_frame.tx_position;
          word[75:12]  = drv_frame.voice_low;
          word[83:76]  = drv_frame.voice_high;
          word[107:84] = drv_frame.slow_data;
          in_tdata  <= word;
          in_tlast  <= drv_frame.end_flag;
          in_tvalid <= 1'b1;
          in_gap    <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each result transfer against the oldest prediction; stall at random
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_slots.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[63:0], '0);
        end else begin
          want = expected_slots.pop_front();
          if (out_tuser !== want.store_valid)
            report_mismatch("store_valid", out_tuser, want.store_valid);
          if (out_tdata[6:0] !== want.slot_index)
            report_mismatch("slot_index", out_tdata[6:0], want.slot_index);
          if (out_tdata[70:7] !== want.voice_low_out)
            report_mismatch("voice_low_out", out_tdata[70:7], want.voice_low_out);
          if (out_tdata[78:71] !== want.voice_high_out)
            report_mismatch("voice_high_out", out_tdata[78:71], want.voice_high_out);
          if (out_tdata[102:79] !== want.slow_data_out)
            report_mismatch("slow_data_out", out_tdata[102:79], want.slow_data_out);
          if (out_tlast !== want.end_transmit)
            report_mismatch("end_transmit", out_tlast, want.end_transmit);
        end
      end
      if (out_stall > 0) begin
        out_stall  <= out_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall  <= pick_gap();
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int counted;
    int num;
    int pos;
    int len;
    int k;

    // Directed: field extremes and each placement rule
    add_frame(31, 1'b1, 127, '1, '1, END_SLOW_PATTERN);          // end flag alone
    add_frame(0, 1'b0, 0, '0, '0, '0);                           // first frame, slot 0
    add_frame(1, 1'b0, 2, '1, '1, '1);                           // too close behind tx
    add_frame(1, 1'b0, 60, 64'h0123_4567_89ab_cdef, 8'h5a, 24'h123456); // repeat number
    add_frame(20, 1'b0, 127, 64'hfedc_ba98_7654_3210, 8'ha5, 24'hedcba9); // tx out of range
    add_frame(0, 1'b0, 40, '0, '1, '0);                          // zero after last number
    add_frame(21, 1'b0, 10, '1, '1, '1);                         // number out of range
    add_frame(31, 1'b0, 84, '1, '0, END_SLOW_PATTERN);
    add_frame(5, 1'b0, 83, '0, '0, END_SLOW_PATTERN);            // slow-data end pattern
    add_frame(6, 1'b0, 84, '1, '1, 24'h555554);
    add_frame(0, 1'b1, 0, '0, '0, '0);
    // repeats walk the area around the ring and back to zero
    for (k = 0; k < 5; k++) add_random_frame(7, 1'b0, 127 - k);
    for (k = 2; k < 12; k++) add_random_frame(k, 1'b0, $urandom_range(0, 127));

    // Random: mostly in-order runs, the rest noise and broken runs
    counted = 0;
    while (counted < RAND_FRAMES) begin
      if ($urandom_range(0, 99) < 70) begin
        num = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SYNC - 1) : 0;
        pos = ($urandom_range(0, 19) == 0) ? $urandom_range(RING, 127)
                                           : $urandom_range(0, RING - 1);
        len = $urandom_range(5, 30);
        for (k = 0; k < len; k++) begin
          add_random_frame(num, 1'b0, pos);
          counted++;
          num = (num + (($urandom_range(0, 9) == 0) ? 2 : 1)) % SYNC;
          if ($urandom_range(0, 1) == 1) pos = (pos + 1) % 128;
        end
        if ($urandom_range(0, 9) < 3) begin
          add_random_frame($urandom_range(0, 31), 1'b1, $urandom_range(0, 127));
          counted++;
        end
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          num = $urandom_range(0, 31);
          if ($urandom_range(0, 9) == 0) begin
            add_random_frame(num, 1'b1, $urandom_range(0, 127));
            counted++;
          end else begin
            add_random_frame(num, 1'b0, $urandom_range(0, 127));
            if (num < SYNC) counted++;
          end
        end
      end
    end

    // Hold reset at the start, then release it
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transfer, every result, then a short drain
    while (frames_sent < frames_total) @(posedge clk);
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== voice_frame_slot_placer.f =====
rtl/vfsp_pkg.sv
rtl/vfsp_place.sv
rtl/voice_frame_slot_placer.sv
dv/tb.sv
